### design/twm_pkg.sv
`default_nettype none
package twm_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int T_W      = 48;
    localparam int DIV_BITS = 49;
    localparam int CNT_W    = 6;
    localparam int ATAN_LEN = 24;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_CLIP = 3'd1;
    localparam logic [2:0] KIND_SAW  = 3'd2;
    localparam logic [2:0] KIND_TRI  = 3'd3;
    localparam logic [2:0] KIND_SINE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE  = 3'd6;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

    typedef enum logic [3:0] {
        OP_NONE, OP_MUL_T, OP_T, OP_PREP, OP_DIV, OP_ANG,
        OP_CORDIC, OP_SCLAMP, OP_SMUL, OP_COMMIT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_T, ST_PREP, ST_DIV, ST_ANG,
        ST_CORDIC, ST_SCLAMP, ST_SMUL, ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic is_div;
        logic is_sine;
        logic div_last;
        logic cordic_last;
        logic out_free;
    } status_t;

    // arctangent of 2^-i in Q0.32 turns
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/twm_ctrl.sv
`default_nettype none
module twm_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire twm_pkg::status_t status,
    output twm_pkg::cmd_t        cmd
);
    import twm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_MUL;
            ST_MUL:     state_next = ST_T;
            ST_T:       state_next = ST_PREP;
            ST_PREP: begin
                if (status.is_div)       state_next = ST_DIV;
                else if (status.is_sine) state_next = ST_ANG;
                else                     state_next = ST_FINISH;
            end
            ST_DIV:     if (status.div_last) state_next = ST_FINISH;
            ST_ANG:     state_next = ST_CORDIC;
            ST_CORDIC:  if (status.cordic_last) state_next = ST_SCLAMP;
            ST_SCLAMP:  state_next = ST_SMUL;
            ST_SMUL:    state_next = ST_FINISH;
            ST_FINISH:  if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd.load = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL:    cmd.op = OP_MUL_T;
            ST_T:      cmd.op = OP_T;
            ST_PREP:   cmd.op = OP_PREP;
            ST_DIV:    cmd.op = OP_DIV;
            ST_ANG:    cmd.op = OP_ANG;
            ST_CORDIC: cmd.op = OP_CORDIC;
            ST_SCLAMP: cmd.op = OP_SCLAMP;
            ST_SMUL:   cmd.op = OP_SMUL;
            ST_FINISH: if (status.out_free) cmd.op = OP_COMMIT;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

### design/twm_datapath.sv
`default_nettype none
module twm_datapath #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [twm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [twm_pkg::DATA_W-1:0]        cfg_data,
    input  wire logic [31:0]                       s_tdata,
    input  wire logic                              s_tuser,
    input  wire twm_pkg::cmd_t                     cmd,
    output twm_pkg::status_t                       status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [63:0]                            m_tdata,
    output logic                                   m_tuser
);
    import twm_pkg::*;

    localparam int CORDIC_N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    logic signed [31:0] gain_reg, offset_reg, low_reg, high_reg, rate_reg;
    logic [2:0]         kind_reg;
    logic [15:0]        phase_reg;

    logic signed [31:0] ev_reg;
    logic               restart_reg;
    logic signed [63:0] prod_reg;
    logic signed [T_W-1:0] t_reg;
    logic [DIV_BITS-1:0] mag_reg;
    logic               neg_reg;
    logic [33:0]        divisor_reg, rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [31:0]        s_reg;
    logic signed [31:0] prev_reg;
    logic               prev_valid_reg;
    logic               m_tvalid_reg;
    logic signed [31:0] mapped_reg, step_reg;
    logic               empty_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= 32'sd65536;
            offset_reg <= '0;
            kind_reg   <= KIND_NONE;
            low_reg    <= '0;
            high_reg   <= 32'sd65536;
            rate_reg   <= 32'sd10430;
            phase_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_data;
                REG_OFFSET: offset_reg <= cfg_data;
                REG_KIND:   kind_reg   <= cfg_data[2:0];
                REG_LOW:    low_reg    <= cfg_data;
                REG_HIGH:   high_reg   <= cfg_data;
                REG_RATE:   rate_reg   <= cfg_data;
                REG_PHASE:  phase_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic signed [32:0] d;
    logic               empty;
    logic signed [48:0] a_diff;
    assign d      = 33'(high_reg) - 33'(low_reg);
    assign empty  = (kind_reg == KIND_CLIP || kind_reg == KIND_SAW ||
                     kind_reg == KIND_TRI || kind_reg == KIND_SINE) && (d <= 33'sd0);
    assign a_diff = 49'(t_reg) - 49'(low_reg);

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_T: begin mul_a = 33'(gain_reg); mul_b = 33'(ev_reg); end
            OP_PREP:  begin mul_a = 33'(rate_reg); mul_b = {1'b0, t_reg[31:0]}; end
            OP_SMUL:  begin mul_a = {1'b0, d[31:0]}; mul_b = {1'b0, s_reg}; end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider step
    logic [34:0] div_sh;
    logic        div_ge;
    assign div_sh = {rem_reg, mag_reg[DIV_BITS-1]};
    assign div_ge = div_sh >= {1'b0, divisor_reg};

    // angle with quarter mirroring
    logic [31:0] ang, ang_m;
    assign ang   = prod_reg[31:0] + {phase_reg, 16'd0};
    assign ang_m = (ang >= 32'h4000_0000 && ang < 32'hC000_0000) ? 32'h8000_0000 - ang : ang;

    // CORDIC step
    logic signed [33:0] xs, ys, at;
    assign xs = x_reg >>> cnt_reg[4:0];
    assign ys = y_reg >>> cnt_reg[4:0];
    assign at = {2'b00, atan_turns(cnt_reg[4:0])};

    logic signed [33:0] yc;
    always_comb begin
        yc = y_reg;
        if (y_reg > ONE_Q30)  yc = ONE_Q30;
        if (y_reg < -ONE_Q30) yc = -ONE_Q30;
    end

    // final result
    logic [33:0]        r_fix;
    logic signed [35:0] rr;
    logic [32:0]        part;
    logic signed [31:0] mapped;
    logic signed [32:0] diff;
    logic signed [31:0] step;
    always_comb begin
        r_fix = (neg_reg && rem_reg != '0) ? divisor_reg - rem_reg : rem_reg;
        rr    = 36'(low_reg) + $signed({2'b00, r_fix});
        if (kind_reg == KIND_TRI && rr > 36'(high_reg))
            rr = $signed({high_reg[31], high_reg[31], high_reg[31], high_reg, 1'b0}) - rr;
        part = prod_reg[63:31];
        if (part > {1'b0, d[31:0]}) part = {1'b0, d[31:0]};
        priority if (empty) begin
            mapped = low_reg;
        end else if (kind_reg == KIND_CLIP) begin
            if (t_reg < 48'(low_reg))       mapped = low_reg;
            else if (t_reg > 48'(high_reg)) mapped = high_reg;
            else                            mapped = t_reg[31:0];
        end else if (kind_reg == KIND_SAW || kind_reg == KIND_TRI) begin
            mapped = rr[31:0];
        end else if (kind_reg == KIND_SINE) begin
            mapped = low_reg + part[31:0];
        end else begin
            if (t_reg > 48'sh7FFF_FFFF)      mapped = 32'sh7FFF_FFFF;
            else if (t_reg < -48'sh8000_0000) mapped = 32'sh8000_0000;
            else                             mapped = t_reg[31:0];
        end
        diff = 33'(mapped) - 33'(prev_reg);
        if (!prev_valid_reg || restart_reg) step = '0;
        else if (diff[32] != diff[31])      step = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else                                step = diff[31:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ev_reg      <= s_tdata;
            restart_reg <= s_tuser;
        end
        unique case (cmd.op)
            OP_MUL_T, OP_SMUL: prod_reg <= mul_p[63:0];
            OP_T: t_reg <= prod_reg[63:16] + 48'(offset_reg);
            OP_PREP: begin
                prod_reg    <= mul_p[63:0];
                neg_reg     <= a_diff[48];
                mag_reg     <= a_diff[48] ? DIV_BITS'(-a_diff) : DIV_BITS'(a_diff);
                divisor_reg <= (kind_reg == KIND_TRI) ? {d[32:0], 1'b0} : {1'b0, d};
                rem_reg     <= '0;
                cnt_reg     <= '0;
            end
            OP_DIV: begin
                rem_reg <= div_ge ? 34'(div_sh - {1'b0, divisor_reg}) : div_sh[33:0];
                mag_reg <= {mag_reg[DIV_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_ANG: begin
                x_reg   <= CORDIC_START;
                y_reg   <= '0;
                z_reg   <= 34'($signed(ang_m));
                cnt_reg <= '0;
            end
            OP_CORDIC: begin
                if (!z_reg[33]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_SCLAMP: s_reg <= 32'(yc + ONE_Q30);
            OP_COMMIT: begin
                mapped_reg <= mapped;
                step_reg   <= step;
                empty_reg  <= empty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_COMMIT) begin
                m_tvalid_reg   <= 1'b1;
                prev_reg       <= mapped;
                prev_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.is_div      = !empty && (kind_reg == KIND_SAW || kind_reg == KIND_TRI);
    assign status.is_sine     = !empty && kind_reg == KIND_SINE;
    assign status.div_last    = cnt_reg == CNT_W'(DIV_BITS - 1);
    assign status.cordic_last = cnt_reg == CNT_W'(CORDIC_N - 1);
    assign status.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {step_reg, mapped_reg};
    assign m_tuser  = empty_reg;

    a_empty_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && empty_reg |-> mapped_reg == low_reg)
        else $error("empty range result differs from range_low");

    a_clip_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !empty_reg && kind_reg == KIND_CLIP
            |-> mapped_reg >= low_reg && mapped_reg <= high_reg)
        else $error("clipped time outside range");

    a_saw_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !empty_reg && kind_reg == KIND_SAW
            |-> mapped_reg >= low_reg && mapped_reg < high_reg)
        else $error("sawtooth time outside range");

    a_first_step_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_COMMIT && !prev_valid_reg |=> step_reg == '0)
        else $error("first step after reset not zero");

endmodule
`default_nettype wire

### design/time_warp_wrap_mapper.sv
// channel  | direction | tdata (low bit up)            | tuser
// s_       | in        | event_time[31:0]              | restart
// m_       | out       | mapped_time[31:0], time_step  | range_empty
// cfg_     | in        | cfg_data written to cfg_index | -
//
// Modes none and clip run the multiply, offset, prepare and finish states; with a
// non-empty range sawtooth and triangular add the bit-serial remainder division,
// sine adds angle, CORDIC iterations capped at 24, clamp and scale.
// A new transfer is taken once the previous item has been handed to the
// output register, so the next item runs while a result waits on m_tready.
// aresetn is synchronous; it restores register defaults and clears the
// previous time.
`default_nettype none
module time_warp_wrap_mapper #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // event_time
    input  wire logic        s_tuser,   // restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // mapped_time, time_step
    output logic             m_tuser    // range_empty
);
    import twm_pkg::*;

    cmd_t    cmd;
    status_t status;

    twm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    twm_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
